@@ rtl/stepper_ramp_pulse_generator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the step-pulse generator
// Compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef STEPPER_RAMP_PULSE_GENERATOR_ASSERT_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRPG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRPG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRPG_ASSERT(label, clk, rst, prop, msg)
`define SRPG_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/srpg_pkg.sv @@
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared constants and types of the step-pulse generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srpg_pkg;

   localparam int DEF_COUNT_BITS    = 32;
   localparam int DEF_FRACTION_BITS = 8;

   localparam int OP_W       = 3;
   localparam int STEPS_W    = 32;
   localparam int READING_W  = 12;
   localparam int POS_W      = 32;
   localparam int IVL_OUT_W  = 22;
   localparam int START_W    = 14;
   localparam int SHORT_W    = 10;
   localparam int HALF_W     = 13;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_W-1:0] OP_MOVE     = 3'd1;
   localparam logic [OP_W-1:0] OP_JOYSTICK = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP     = 3'd3;
   localparam logic [OP_W-1:0] OP_ZERO     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_START_INTERVAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORTEST_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JOYSTICK_CENTER   = 2'd2;

   localparam logic [START_W-1:0]   RST_START_INTERVAL    = 14'd6200;
   localparam logic [SHORT_W-1:0]   RST_SHORTEST_INTERVAL = 10'd100;
   localparam logic [READING_W-1:0] RST_JOYSTICK_CENTER   = 12'd2048;

   localparam logic [READING_W-1:0] DEAD_BAND    = 12'd200;
   localparam logic [READING_W-1:0] READING_FULL = 12'd4095;
   localparam logic [START_W-1:0]   JOY_FLOOR_US = 14'd1750;

   typedef struct packed {
      logic busy;
      logic done;
   } srpg_div_stat_type;

endpackage

`default_nettype wire

@@ rtl/stepper_ramp_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Step-pulse generator for one motor with linear ramps and joystick mode.
// ----------------------------------------------------------------------------
// Requests arrive on req_*: tuser carries the operation (tick, move,
// joystick sample, stop, zero position), tdata the step count and the
// joystick reading. Every request yields exactly one response on rsp_*
// holding the pin levels, status flags, position and current interval.
// Registers are written through csr_*; the user must write them only while
// the block is idle, which the block itself does not check. A plain request
// passes through S_EMIT, which loads the response into the output register.
// A tick that ends a step of a finite move in a ramp runs the shared serial
// divider, one quotient bit per cycle. A joystick sample outside the
// deadzone first passes through S_MUL to form the product for the divider.
// One request is in flight at a time; req_tready rises again when the
// response is loaded into the output register, and a new request is taken
// as long as that register is empty or being drained.
// Reset clears all motion state, loads the default registers and sets the
// interval to the start interval. A stalled receiver holds the response;
// no further request is taken until it is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_ramp_pulse_generator_assert.svh"

module stepper_ramp_pulse_generator
   import srpg_pkg::*;
#(
   parameter int COUNT_BITS    = DEF_COUNT_BITS,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // move_steps[31:0], joystick_reading[43:32]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // operation[2:0]
   input  wire logic [OP_W-1:0]       req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // step_out[0], direction_out[1], running[2], move_done[3],
   // position[35:4], step_interval[57:36]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CB    = COUNT_BITS;
   localparam int IB    = START_W + FRACTION_BITS;
   localparam int DVD_W = IB + READING_W;
   localparam int DVS_W = CB + 2;
   localparam logic [CB-1:0] CNT_MAX = '1;
   localparam logic [IB-1:0] IVL_MAX = '1;
   localparam logic [IB-1:0] JOY_FLOOR = {JOY_FLOOR_US, {FRACTION_BITS{1'b0}}};

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_EMIT} state_type;
   typedef enum logic [1:0] {K_UP, K_DOWN, K_JOY} kind_type;

   typedef struct packed {
      logic                level;
      logic                active;
      logic                cont;
      logic                fin;
      logic                rev;
      logic [POS_W-1:0]    pos;
      logic [CB-1:0]       taken;
      logic [CB-1:0]       wanted;
      logic [CB-1:0]       rlen;
      logic [CB-1:0]       ridx;
      logic [IB-1:0]       ivl;
      logic [HALF_W-1:0]   half;
      logic [HALF_W-1:0]   tleft;
   } motor_type;

   function automatic logic [HALF_W-1:0] arm_of(input logic [HALF_W-1:0] d);
      arm_of = (d == '0) ? HALF_W'(1) : d;
   endfunction

   function automatic logic [HALF_W-1:0] half_of(input logic [IB-1:0] c);
      half_of = c[FRACTION_BITS+HALF_W : FRACTION_BITS+1];
   endfunction

   state_type            state_ff, state_in;
   kind_type             kind_ff, kind_in;
   motor_type            mot_ff, mot_in;
   logic [START_W-1:0]   start_ff, start_in;
   logic [SHORT_W-1:0]   short_ff, short_in;
   logic [READING_W-1:0] center_ff, center_in;
   logic [READING_W-1:0] ad_ff, ad_in;
   logic [READING_W-1:0] span_ff, span_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic                 go_ff, go_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   srpg_div_stat_type    div_stat;
   logic [DVD_W-1:0]     div_quo;
   logic [IB-1:0]        quo;

   logic                 accept;
   logic [OP_W-1:0]      op;
   logic [STEPS_W-1:0]   raw_steps;
   logic [STEPS_W-1:0]   mag;
   logic [READING_W-1:0] reading;
   logic [READING_W:0]   delta;
   logic [READING_W-1:0] ad;
   logic [READING_W-1:0] span_raw;
   logic [IB-1:0]        ivl_st;
   logic [IB-1:0]        ivl_sh;
   logic [IB-1:0]        diff;
   logic [CB-1:0]        taken_inc;
   logic [CB-1:0]        idx_up;
   logic [CB-1:0]        idx_dn;
   logic [CB-1:0]        thr;
   logic [IB-1:0]        c_up;
   logic [IB+1:0]        c_dn;
   logic [IB-1:0]        want;

   assign accept    = req_tvalid && req_tready;
   assign op        = req_tuser;
   assign raw_steps = req_tdata[STEPS_W-1:0];
   assign reading   = req_tdata[STEPS_W+READING_W-1:STEPS_W];
   assign mag       = raw_steps[STEPS_W-1] ? (~raw_steps + 1'b1) : raw_steps;
   assign delta     = {1'b0, reading} - {1'b0, center_ff};
   assign ad        = delta[READING_W] ? READING_W'(~delta + 1'b1) : delta[READING_W-1:0];
   assign span_raw  = delta[READING_W] ? center_ff : READING_FULL - center_ff;
   assign ivl_st    = {start_ff, {FRACTION_BITS{1'b0}}};
   assign ivl_sh    = {{(START_W-SHORT_W){1'b0}}, short_ff, {FRACTION_BITS{1'b0}}};
   assign diff      = (ivl_st >= ivl_sh) ? ivl_st - ivl_sh : ivl_sh - ivl_st;
   assign taken_inc = mot_ff.taken + 1'b1;
   assign idx_up    = (mot_ff.ridx != CNT_MAX) ? mot_ff.ridx + 1'b1 : mot_ff.ridx;
   assign idx_dn    = mot_ff.ridx - 1'b1;
   assign thr       = (mot_ff.wanted >= mot_ff.rlen) ? mot_ff.wanted - mot_ff.rlen : '0;
   assign quo       = div_quo[IB-1:0];
   assign c_up      = mot_ff.ivl - quo;
   assign c_dn      = {2'b00, mot_ff.ivl} + {2'b00, quo};
   assign want      = (ivl_st >= ivl_sh) ? ivl_st - quo : ivl_st + quo;

   srpg_divider #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .dividend (dvd_ff),
      .divisor  (dvs_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      mot_in       = mot_ff;
      start_in     = start_ff;
      short_in     = short_ff;
      center_in    = center_ff;
      ad_in        = ad_ff;
      span_in      = span_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      go_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_START_INTERVAL:    start_in  = csr_wdata;
            CSR_SHORTEST_INTERVAL: short_in  = csr_wdata[SHORT_W-1:0];
            CSR_JOYSTICK_CENTER:   center_in = csr_wdata[READING_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EMIT;
               case (op)
                  OP_TICK: begin
                     if (mot_ff.active) begin
                        if (mot_ff.tleft > HALF_W'(1)) begin
                           mot_in.tleft = mot_ff.tleft - 1'b1;
                        end else if (!mot_ff.cont && mot_ff.taken >= mot_ff.wanted) begin
                           mot_in.fin    = 1'b1;
                           mot_in.active = 1'b0;
                        end else if (!mot_ff.level) begin
                           mot_in.level = 1'b1;
                           mot_in.tleft = arm_of(mot_ff.half);
                        end else begin
                           mot_in.level = 1'b0;
                           mot_in.taken = taken_inc;
                           mot_in.pos   = mot_ff.rev ? mot_ff.pos - 1'b1 : mot_ff.pos + 1'b1;
                           mot_in.half  = half_of(mot_ff.ivl);
                           mot_in.tleft = arm_of(half_of(mot_ff.ivl));
                           if (!mot_ff.cont) begin
                              if (mot_ff.rlen == '0) begin
                                 // accelerate: divide 2c by 4n+1
                                 mot_in.ridx = idx_up;
                                 dvd_in      = DVD_W'({mot_ff.ivl, 1'b0});
                                 dvs_in      = {idx_up, 2'b01};
                                 kind_in     = K_UP;
                                 go_in       = 1'b1;
                                 state_in    = S_DIV;
                              end else if (taken_inc >= thr && mot_ff.ridx > CB'(1)) begin
                                 // decelerate: divide 2c by 4n-1
                                 mot_in.ridx = idx_dn;
                                 dvd_in      = DVD_W'({mot_ff.ivl, 1'b0});
                                 dvs_in      = {idx_dn - 1'b1, 2'b11};
                                 kind_in     = K_DOWN;
                                 go_in       = 1'b1;
                                 state_in    = S_DIV;
                              end
                           end
                        end
                     end
                  end
                  OP_MOVE: begin
                     mot_in.wanted = (mag > 32'(CNT_MAX)) ? CNT_MAX : mag[CB-1:0];
                     mot_in.taken  = '0;
                     mot_in.rlen   = '0;
                     mot_in.ridx   = '0;
                     mot_in.fin    = 1'b0;
                     mot_in.level  = 1'b0;
                     mot_in.cont   = 1'b0;
                     mot_in.rev    = raw_steps[STEPS_W-1];
                     mot_in.ivl    = ivl_st;
                     mot_in.half   = half_of(ivl_st);
                     mot_in.active = 1'b1;
                     mot_in.tleft  = arm_of(half_of(ivl_st));
                  end
                  OP_JOYSTICK: begin
                     if (ad <= DEAD_BAND) begin
                        if (mot_ff.active) begin
                           mot_in.active = 1'b0;
                           mot_in.cont   = 1'b0;
                           mot_in.fin    = 1'b1;
                           mot_in.level  = 1'b0;
                        end
                     end else begin
                        mot_in.rev = delta[READING_W];
                        ad_in      = ad;
                        span_in    = (span_raw < ad) ? ad : span_raw;
                        state_in   = S_MUL;
                     end
                  end
                  OP_STOP: begin
                     if (mot_ff.active) begin
                        mot_in.active = 1'b0;
                        mot_in.cont   = 1'b0;
                        mot_in.fin    = 1'b1;
                        mot_in.level  = 1'b0;
                     end
                  end
                  OP_ZERO: mot_in.pos = '0;
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            dvd_in   = {{IB{1'b0}}, ad_ff} * {{READING_W{1'b0}}, diff};
            dvs_in   = DVS_W'(span_ff);
            kind_in  = K_JOY;
            go_in    = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_EMIT;
               case (kind_ff)
                  K_UP: begin
                     mot_in.ivl   = (c_up <= ivl_sh) ? ivl_sh : c_up;
                     mot_in.half  = half_of((c_up <= ivl_sh) ? ivl_sh : c_up);
                     mot_in.tleft = arm_of(half_of((c_up <= ivl_sh) ? ivl_sh : c_up));
                     if (c_up <= ivl_sh || mot_ff.taken >= (mot_ff.wanted >> 1)) begin
                        mot_in.rlen = mot_ff.taken;
                     end
                  end
                  K_DOWN: begin
                     mot_in.ivl   = (c_dn > {2'b00, IVL_MAX}) ? IVL_MAX : c_dn[IB-1:0];
                     mot_in.half  = half_of((c_dn > {2'b00, IVL_MAX}) ? IVL_MAX : c_dn[IB-1:0]);
                     mot_in.tleft = arm_of(half_of((c_dn > {2'b00, IVL_MAX}) ?
                                                   IVL_MAX : c_dn[IB-1:0]));
                  end
                  K_JOY: begin
                     mot_in.ivl  = (want < JOY_FLOOR) ? JOY_FLOOR : want;
                     mot_in.half = half_of((want < JOY_FLOOR) ? JOY_FLOOR : want);
                     if (!mot_ff.active) begin
                        mot_in.cont   = 1'b1;
                        mot_in.fin    = 1'b0;
                        mot_in.level  = 1'b0;
                        mot_in.taken  = '0;
                        mot_in.active = 1'b1;
                        mot_in.tleft  = arm_of(half_of((want < JOY_FLOOR) ? JOY_FLOOR : want));
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {{(RSP_DATA_W-IVL_OUT_W-POS_W-4){1'b0}}, IVL_OUT_W'(mot_ff.ivl),
                            mot_ff.pos, mot_ff.fin, mot_ff.active, mot_ff.rev, mot_ff.level};
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= K_UP;
         mot_ff       <= '{level: 1'b0, active: 1'b0, cont: 1'b0, fin: 1'b0, rev: 1'b0,
                           pos: '0, taken: '0, wanted: '0, rlen: '0, ridx: '0,
                           ivl: {RST_START_INTERVAL, {FRACTION_BITS{1'b0}}},
                           half: RST_START_INTERVAL[START_W-1:1], tleft: '0};
         start_ff     <= RST_START_INTERVAL;
         short_ff     <= RST_SHORTEST_INTERVAL;
         center_ff    <= RST_JOYSTICK_CENTER;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         mot_ff       <= mot_in;
         start_ff     <= start_in;
         short_ff     <= short_in;
         center_ff    <= center_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ad_ff       <= ad_in;
      span_ff     <= span_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SRPG_ASSERT(a_one_in_flight, clock, reset, accept |=> !req_tready, "request overlap")
   `SRPG_ASSERT(a_done_excl, clock, reset,
                rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[3]), "running and done together")
   `SRPG_ASSERT(a_div_owned, clock, reset, div_stat.done |-> (state_ff == S_DIV), "stray divider result")
   `SRPG_ASSERT(a_rsp_drain, clock, reset, (rsp_tvalid && rsp_tready) |=> !rsp_tvalid, "response repeated")

endmodule

`default_nettype wire

@@ rtl/srpg_divider.sv @@
// ----------------------------------------------------------------------------
// srpg_divider
// Restoring divider, one quotient bit per cycle, shared by all ramp and
// joystick interval calculations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srpg_divider
   import srpg_pkg::*;
#(
   parameter int DVD_W = 34,
   parameter int DVS_W = 34
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output srpg_div_stat_type     stat,
   output logic      [DVD_W-1:0] quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   shifted;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_W'(shifted - {1'b0, dvs_ff}) : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

`default_nettype wire
